// ----- rtl/rdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and codes of the restricted deque: operation and status codes,
// mode values, sizes and the control word that drives the row of cells.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OCC_W   = 5;
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_EMPTY       = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOWED = 2'd3;

    localparam logic MODE_IN_RESTRICT  = 1'b0;
    localparam logic MODE_OUT_RESTRICT = 1'b1;

    // register index taken from paddr above the byte offset
    localparam logic [ADDR_W-3:0] REG_MODE = '0;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]  t_count;

    // one-hot action for the whole row in a given cycle, or all zero when the row holds
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } t_cell_ctrl;

endpackage

// ----- rtl/rdq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_cell
// One slot of the deque. Holds a value and an occupied flag and trades data
// with its front-side and back-side neighbors.
// ----------------------------------------------------------------------------
module rdq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rdq_pkg::t_cell_ctrl i_ctrl,
    input  rdq_pkg::t_data      i_push_data,
    input  logic                i_left_valid,
    input  rdq_pkg::t_data      i_left_data,
    input  logic                i_right_valid,
    input  rdq_pkg::t_data      i_right_data,
    output logic                o_valid,
    output rdq_pkg::t_data      o_data,
    output logic                o_tail
);
    import rdq_pkg::*;

    logic  r_valid, n_valid;
    t_data r_data, n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.push_front) begin
            // shift toward the back
            n_valid = i_left_valid;
            n_data  = i_left_data;
        end else if (i_ctrl.pop_front) begin
            // shift toward the front
            n_valid = i_right_valid;
            n_data  = i_right_data;
        end else if (i_ctrl.push_back) begin
            if (!r_valid && i_left_valid) begin
                n_valid = 1'b1;
                n_data  = i_push_data;
            end
        end else if (i_ctrl.pop_back) begin
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_tail  = r_valid && !i_right_valid;

endmodule

// ----- rtl/rdq_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_chain
// Row of DEPTH cells, front at cell 0. Presents the front value and the value
// of the last occupied cell.
// ----------------------------------------------------------------------------
module rdq_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rdq_pkg::t_cell_ctrl i_ctrl,
    input  rdq_pkg::t_data      i_push_data,
    output rdq_pkg::t_data      o_front_data,
    output rdq_pkg::t_data      o_back_data
);
    import rdq_pkg::*;

    logic  w_valid [DEPTH];
    t_data w_data  [DEPTH];
    logic  w_tail  [DEPTH];
    t_data w_back;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic  w_lv, w_rv;
        t_data w_ld, w_rd;

        if (g == 0) begin : g_first
            // the push value enters at the front
            assign w_lv = 1'b1;
            assign w_ld = i_push_data;
        end else begin : g_mid_l
            assign w_lv = w_valid[g-1];
            assign w_ld = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rv = 1'b0;
            assign w_rd = '0;
        end else begin : g_mid_r
            assign w_rv = w_valid[g+1];
            assign w_rd = w_data[g+1];
        end

        rdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (i_ctrl),
            .i_push_data  (i_push_data),
            .i_left_valid (w_lv),
            .i_left_data  (w_ld),
            .i_right_valid(w_rv),
            .i_right_data (w_rd),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g]),
            .o_tail       (w_tail[g])
        );
    end

    // at most one cell is the tail
    always_comb begin
        w_back = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back = w_back | (w_data[k] & {DATA_W{w_tail[k]}});
        end
    end

    assign o_front_data = w_data[0];
    assign o_back_data  = w_back;

endmodule

// ----- rtl/restricted_deque_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restricted_deque_top
// Bounded double-ended queue of signed 32-bit values with an input- or
// output-restricted mode, built as a row of shifting cells.
//
//   channel   ports                                        transfer
//   -------   ------------------------------------------   ----------------------
//   command   i_start, o_busy, i_op, i_push_value          start && !busy
//   result    o_result_valid, o_status, o_popped_value,    one-cycle strobe, no stall
//             o_occupancy
//   config    psel, penable, pwrite, paddr, pwdata,        psel && penable && pready
//             prdata, pready
//
// One transaction per cycle: the cell row shifts or loads at the accepting
// edge, and the result shows on the next cycle for exactly one cycle.
// o_busy is never raised; the cell row completes every successful operation in
// a single update, and a failed one leaves the row unchanged.
// Reset (synchronous, active low) empties the row and clears the mode to
// input restricted. The result side cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
module restricted_deque_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_op,
    input  logic signed [rdq_pkg::DATA_W-1:0] i_push_value,
    // result
    output logic                              o_result_valid,
    output logic [1:0]                        o_status,
    output logic signed [rdq_pkg::DATA_W-1:0] o_popped_value,
    output logic [rdq_pkg::OCC_W-1:0]         o_occupancy,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rdq_pkg::ADDR_W-1:0]        paddr,
    input  logic [rdq_pkg::PDATA_W-1:0]       pwdata,
    output logic [rdq_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import rdq_pkg::*;

    logic       r_mode;
    t_count     r_count, n_count;
    logic       r_strobe;
    logic [1:0] r_status, n_status;
    t_data      r_popped, n_popped;
    t_cell_ctrl w_ctrl;
    t_data      w_front, w_back;
    logic       w_accept, w_full, w_empty, w_cfg_wr;
    logic [ADDR_W-3:0] w_reg_idx;

    // --- configuration port ---
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IN_RESTRICT;
        end else if (w_cfg_wr && w_reg_idx == REG_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    assign prdata = (w_reg_idx == REG_MODE) ? PDATA_W'(r_mode) : '0;

    // --- command decode ---
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count == t_count'(DEPTH));
    assign w_empty  = (r_count == '0);

    always_comb begin
        n_status = ST_DONE;
        n_popped = '0;
        n_count  = r_count;
        w_ctrl   = '0;
        case (i_op)
            OP_PUSH_FRONT: begin
                if (r_mode == MODE_IN_RESTRICT) begin
                    n_status = ST_NOT_ALLOWED;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.push_front = w_accept;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.push_back = w_accept;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (r_mode == MODE_OUT_RESTRICT) begin
                    n_status = ST_NOT_ALLOWED;
                end else if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctrl.pop_front = w_accept;
                    n_popped = w_front;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                // pop back is allowed in both modes
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctrl.pop_back = w_accept;
                    n_popped = w_back;
                    n_count  = r_count - 1'b1;
                end
            end
        endcase
    end

    rdq_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_push_data (t_data'(i_push_value)),
        .o_front_data(w_front),
        .o_back_data (w_back)
    );

    // --- count and result register ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // hold the payload of the last transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    assign o_result_valid = r_strobe;
    assign o_status       = r_status;
    assign o_popped_value = $signed(r_popped);
    assign o_occupancy    = OCC_W'(r_count);

endmodule

// ----- rtl/rdq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdq_checker
// Port-level checks on the restricted deque, bound to the top level.
// ----------------------------------------------------------------------------
module rdq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic [1:0]                        i_op,
    input logic signed [rdq_pkg::DATA_W-1:0] i_push_value,
    input logic                              o_result_valid,
    input logic [1:0]                        o_status,
    input logic signed [rdq_pkg::DATA_W-1:0] o_popped_value,
    input logic [rdq_pkg::OCC_W-1:0]         o_occupancy,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [rdq_pkg::ADDR_W-1:0]        paddr,
    input logic [rdq_pkg::PDATA_W-1:0]       pwdata,
    input logic [rdq_pkg::PDATA_W-1:0]       prdata,
    input logic                              pready
);
    import rdq_pkg::*;

    // every transaction gives one result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_result_valid)
        else $error("result missing after accepted transaction");

    // no result without a transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |=> !o_result_valid)
        else $error("result without accepted transaction");

    // failed operations return zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_DONE) |-> (o_popped_value == '0))
        else $error("nonzero value on failed operation");

    // failed operations leave the count unchanged
    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_DONE) |-> $stable(o_occupancy))
        else $error("occupancy moved on failed operation");

    // a successful operation moves the count
    a_done_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_DONE) |-> !$stable(o_occupancy))
        else $error("occupancy unchanged on successful operation");

endmodule

bind restricted_deque_top rdq_checker u_rdq_checker (.*);
